// ===== sv/glzw_pkg.sv =====
// Package for the GIF LZW decoder: status and kind codes, shared constants.
// No dependencies.
package glzw_pkg;
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_PULL  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;
   localparam logic [1:0] KIND_RSVD  = 2'd3;

   localparam logic [2:0] ST_PIXEL   = 3'd0;
   localparam logic [2:0] ST_TAKEN   = 3'd1;
   localparam logic [2:0] ST_REFUSED = 3'd2;
   localparam logic [2:0] ST_NEED    = 3'd3;
   localparam logic [2:0] ST_END     = 3'd4;
   localparam logic [2:0] ST_INVALID = 3'd5;

   localparam logic CSR_MIN_SIZE = 1'b0;
   localparam logic CSR_COLOURS  = 1'b1;
endpackage

// ===== sv/gif_lzw_decoder_top.sv =====
// GIF LZW decoder: each request (stream byte, pixel pull or image start) gives
// exactly one response, and requests are handled one at a time. A byte, a
// start, or a pull that ends without a new string (need bytes, end, invalid
// code, first code after clear) goes from decode straight to the response; a
// pull that pops the expansion stack passes through a stack read state; a pull
// that decodes a new code walks its prefix chain with one prefix/suffix memory
// read per link. Each clear code met inside a pull sends it through decode once
// more. Tables and stack are memories and are read only after being written,
// so no clearing pass is needed. MAX_CODE_BITS may be set from 9 to 12.
// Configuration writes are taken only while idle with no request offered; a
// new minimum code size should be followed by a start request. Depends on
// glzw_pkg.
module gif_lzw_decoder_top #(
   parameter int MAX_CODE_BITS = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_pixel_index,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [0:0] csr_index,
   input  logic [8:0] csr_data
);
   import glzw_pkg::*;
   localparam int DEPTH = 1 << MAX_CODE_BITS;
   localparam int CW = MAX_CODE_BITS;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_DEC   = 6'b000010,
      S_RDSTK = 6'b000100,
      S_WALK  = 6'b001000,
      S_WAIT  = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   // memories
   logic [CW-1:0] prefix_mem [DEPTH];
   logic [7:0]    suffix_mem [DEPTH];
   logic [7:0]    stack_mem  [DEPTH];
   logic [CW-1:0] pre_rd_ff;
   logic [7:0]    suf_rd_ff, stk_rd_ff;
   logic          tw_en, sw_en;
   logic [CW-1:0] tw_addr, t_raddr, s_waddr, s_raddr;
   logic [CW-1:0] tw_pre;
   logic [7:0]    tw_suf, sw_data;

   always_ff @(posedge clock) begin
      if (tw_en) begin
         prefix_mem[tw_addr] <= tw_pre;
         suffix_mem[tw_addr] <= tw_suf;
      end
      if (sw_en) stack_mem[s_waddr] <= sw_data;
      pre_rd_ff <= prefix_mem[t_raddr];
      suf_rd_ff <= suffix_mem[t_raddr];
      stk_rd_ff <= stack_mem[s_raddr];
   end

   state_type     state_ff, state_in;
   logic [3:0]    msize_ff, msize_in;
   logic [8:0]    ccount_ff, ccount_in;
   logic [CW:0]   sc_ff, sc_in;
   logic [23:0]   bb_ff, bb_in;
   logic [4:0]    bc_ff, bc_in;
   logic [3:0]    cw_ff, cw_in;
   logic [CW:0]   nf_ff, nf_in;
   logic [CW-1:0] pc_ff, pc_in;
   logic          pv_ff, pv_in;
   logic [7:0]    fc_ff, fc_in;
   logic [7:0]    br_ff, br_in;
   logic          end_ff, end_in;
   logic [1:0]    kind_ff, kind_in;
   logic [7:0]    db_ff, db_in;
   logic [CW-1:0] code_ff, code_in, c_ff, c_in;
   logic [2:0]    st_ff, st_in;
   logic [7:0]    px_ff, px_in;

   logic [3:0]    emin;
   logic [CW:0]   clr;
   logic [CW-1:0] code_raw;
   logic [CW:0]   codew;
   logic [CW:0]   root;
   logic          deeper;
   logic [7:0]    root_chr;

   assign emin = (msize_ff < 4'd2) ? 4'd2 : (msize_ff > 4'd8) ? 4'd8 : msize_ff;
   assign clr  = (CW+1)'(1) << emin;
   assign code_raw = bb_ff[CW-1:0] & ((CW'(1) << cw_ff) - CW'(1));
   assign codew = {1'b0, code_raw};
   assign root = {1'b0, c_ff};
   // chain continues while the code is above the end code
   assign deeper = (root > clr + (CW+1)'(1));
   assign root_chr = deeper ? 8'd0 : c_ff[7:0];

   assign req_stall = (state_ff != S_IDLE);
   // config only while idle and no request is offered
   assign csr_ready = (state_ff == S_IDLE) && !req_valid;
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_status = st_ff;
   assign rsp_pixel_index = px_ff;

   always_comb begin
      state_in = state_ff; msize_in = msize_ff; ccount_in = ccount_ff;
      sc_in = sc_ff; bb_in = bb_ff; bc_in = bc_ff; cw_in = cw_ff; nf_in = nf_ff;
      pc_in = pc_ff; pv_in = pv_ff; fc_in = fc_ff; br_in = br_ff; end_in = end_ff;
      kind_in = kind_ff; db_in = db_ff; code_in = code_ff; c_in = c_ff;
      st_in = st_ff; px_in = px_ff;
      tw_en = 1'b0; tw_addr = nf_ff[CW-1:0]; tw_pre = pc_ff; tw_suf = root_chr;
      sw_en = 1'b0; s_waddr = sc_ff[CW-1:0]; sw_data = fc_ff;
      t_raddr = c_ff; s_raddr = sc_ff[CW-1:0] - CW'(1);
      case (state_ff)
         S_IDLE: begin
            if (csr_valid && csr_ready) begin
               if (csr_index == CSR_MIN_SIZE) msize_in = csr_data[3:0];
               else ccount_in = csr_data;
            end
            if (req_valid) begin
               kind_in = req_kind; db_in = req_data_byte; state_in = S_DEC;
            end
         end
         S_DEC: begin
            px_in = 8'd0;
            state_in = S_OUT;
            case (kind_ff)
               KIND_BYTE: begin
                  if (end_ff) st_in = ST_REFUSED;
                  else if (br_ff == 8'd0) begin
                     st_in = ST_TAKEN;
                     if (db_ff == 8'd0) end_in = 1'b1; else br_in = db_ff;
                  end else if (bc_ff > 5'd16) st_in = ST_REFUSED;
                  else begin
                     st_in = ST_TAKEN;
                     bb_in = bb_ff | (24'(db_ff) << bc_ff);
                     bc_in = bc_ff + 5'd8;
                     br_in = br_ff - 8'd1;
                  end
               end
               KIND_START: begin
                  cw_in = emin + 4'd1; nf_in = clr + (CW+1)'(2); pv_in = 1'b0;
                  sc_in = '0; bb_in = '0; bc_in = '0; pc_in = '0; fc_in = '0;
                  br_in = '0; end_in = 1'b0; st_in = ST_NEED;
               end
               KIND_PULL: begin
                  if (sc_ff != '0) begin
                     // pop: read of entry sc-1 issued now, data in S_RDSTK
                     sc_in = sc_ff - (CW+1)'(1);
                     state_in = S_RDSTK;
                  end else if (bc_ff < 5'(cw_ff)) st_in = end_ff ? ST_END : ST_NEED;
                  else begin
                     bb_in = bb_ff >> cw_ff;
                     bc_in = bc_ff - 5'(cw_ff);
                     if (codew == clr) begin
                        // clear: restart the table and keep decoding
                        cw_in = emin + 4'd1; nf_in = clr + (CW+1)'(2); pv_in = 1'b0;
                        state_in = S_DEC;
                     end else if (codew == clr + (CW+1)'(1)) begin
                        end_in = 1'b1; bb_in = '0; bc_in = '0; sc_in = '0;
                        st_in = ST_END;
                     end else if (codew < clr && codew >= (CW+1)'(ccount_ff)) begin
                        st_in = ST_INVALID;
                     end else if (!pv_ff) begin
                        if (codew >= clr) st_in = ST_INVALID;
                        else begin
                           pc_in = code_raw; fc_in = code_raw[7:0];
                           pv_in = 1'b1; st_in = ST_PIXEL; px_in = code_raw[7:0];
                        end
                     end else if (codew > nf_ff) st_in = ST_INVALID;
                     else begin
                        code_in = code_raw;
                        c_in = code_raw;
                        // code equals next free: first char goes on first
                        if (codew == nf_ff) begin
                           sw_en = 1'b1; sc_in = sc_ff + (CW+1)'(1); c_in = pc_ff;
                        end
                        state_in = S_WALK;
                     end
                  end
               end
               default: st_in = ST_REFUSED;
            endcase
         end
         // stack read data ready
         S_RDSTK: begin
            st_in = ST_PIXEL; px_in = stk_rd_ff; state_in = S_OUT;
         end
         // chain walk: t_raddr = c_ff issues the read; S_WAIT consumes it
         S_WALK: begin
            if (deeper && sc_ff < (CW+1)'(DEPTH)) state_in = S_WAIT;
            else begin
               if (sc_ff < (CW+1)'(DEPTH)) begin
                  sw_en = 1'b1; sw_data = root_chr;
                  sc_in = sc_ff + (CW+1)'(1);
               end
               // add the new entry unless the table is full
               if (nf_ff < (CW+1)'(DEPTH)) begin
                  tw_en = 1'b1;
                  nf_in = nf_ff + (CW+1)'(1);
                  if (nf_ff + (CW+1)'(1) == ((CW+1)'(1) << cw_ff) && cw_ff < 4'(CW))
                     cw_in = cw_ff + 4'd1;
               end
               pc_in = code_ff;
               fc_in = root_chr;
               state_in = S_DEC;
            end
         end
         // table read data ready: push suffix, follow prefix
         S_WAIT: begin
            sw_en = 1'b1; sw_data = suf_rd_ff; sc_in = sc_ff + (CW+1)'(1);
            c_in = pre_rd_ff; state_in = S_WALK;
         end
         S_OUT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; msize_ff <= 4'd8; ccount_ff <= 9'd256;
         sc_ff <= '0; bb_ff <= '0; bc_ff <= '0; cw_ff <= 4'd9;
         nf_ff <= (CW+1)'(258); pc_ff <= '0; pv_ff <= 1'b0; fc_ff <= '0;
         br_ff <= '0; end_ff <= 1'b0;
      end else begin
         state_ff <= state_in; msize_ff <= msize_in; ccount_ff <= ccount_in;
         sc_ff <= sc_in; bb_ff <= bb_in; bc_ff <= bc_in; cw_ff <= cw_in;
         nf_ff <= nf_in; pc_ff <= pc_in; pv_ff <= pv_in; fc_ff <= fc_in;
         br_ff <= br_in; end_ff <= end_in;
      end
      kind_ff <= kind_in; db_ff <= db_in; code_ff <= code_in; c_ff <= c_in;
      st_ff <= st_in; px_ff <= px_in;
   end

`ifndef NO_ASSERTIONS
   // no new request while a response is pending
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken during response");
   // stack never exceeds its depth
   a_stack: assert property (@(posedge clock) disable iff (reset)
      sc_ff <= (CW+1)'(DEPTH)) else $error("stack overflow");
   // pixel index is zero unless status is pixel
   a_pix: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_PIXEL) |-> rsp_pixel_index == 8'd0)
      else $error("stray pixel index");
`endif
endmodule
